// ===== rtl/bfh_pkg.sv =====
// Shared types, codes and helpers for the back/forward history ring.
package bfh_pkg;

   // Built depth of the entry store
   localparam int DEPTH_DEFAULT = 128;

   // Capacity register reset value and the slot count used for a zero write
   localparam logic [7:0] CAPACITY_RESET = 8'd100;
   localparam logic [7:0] DEFAULT_SLOTS  = 8'd100;

   // Operation codes
   localparam logic [1:0] FUNC_PUSH = 2'd0;
   localparam logic [1:0] FUNC_BACK = 2'd1;
   localparam logic [1:0] FUNC_FWD  = 2'd2;

   // Where the position fields of a result come from
   typedef enum logic [2:0] {
      SRC_ZERO = 3'b001,
      SRC_PUSH = 3'b010,
      SRC_MEM  = 3'b100
   } bfh_src_type;

   // Per-item result control and status
   typedef struct packed {
      logic        moved;
      bfh_src_type src;
      logic        can_back;
      logic        can_forward;
      logic [7:0]  held;
   } bfh_result_type;

   // One stored history entry
   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [4:0]  level;
   } bfh_entry_type;

   // Slots in use for a written capacity value, limited to the built depth
   function automatic logic [7:0] eff_cap(input logic [7:0] value, input int depth);
      logic [7:0] c;
      c = (value == 8'd0) ? DEFAULT_SLOTS : value;
      if (int'(c) > depth) begin
         c = 8'(depth);
      end
      return c;
   endfunction

   // (a + b) mod cap, for a < cap and b < cap
   function automatic logic [7:0] wrap_add(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] cap);
      logic [8:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= {1'b0, cap}) begin
         sum = sum - {1'b0, cap};
      end
      return sum[7:0];
   endfunction

endpackage

// ===== rtl/bfh_store.sv =====
// Entry store: one write and one registered read per cycle.
module bfh_store
   import bfh_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  bfh_entry_type wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output bfh_entry_type rd_data
);

   bfh_entry_type mem [DEPTH];
   bfh_entry_type rd_data_ff;

   // Write the pushed entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read the entry that becomes current; hold it until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bfh_ctrl.sv =====
// Pointer control: capacity, oldest slot, cursor and entry count.
module bfh_ctrl
   import bfh_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step_en,
   input  logic [1:0]     func,
   input  logic           csr_we,
   input  logic [7:0]     csr_wdata,
   output logic           wr_en,
   output logic [AW-1:0]  wr_addr,
   output logic           rd_en,
   output logic [AW-1:0]  rd_addr,
   output bfh_result_type result
);

   // cur_ff holds cursor plus one, so zero means no current entry
   logic [7:0] cap_ff,    cap_in;
   logic [7:0] oldest_ff, oldest_in;
   logic [7:0] cur_ff,    cur_in;
   logic [7:0] held_ff,   held_in;

   logic [7:0] slot_cur;
   logic [7:0] slot_prev;
   logic [8:0] oldest_inc;

   // Slot of logical index cursor+1 (push append, forward) and cursor-1 (back)
   assign slot_cur   = wrap_add(oldest_ff, cur_ff, cap_ff);
   assign slot_prev  = wrap_add(oldest_ff, cur_ff - 8'd2, cap_ff);
   assign oldest_inc = {1'b0, oldest_ff} + 9'd1;

   // Work out the next pointers, store access and result
   always_comb begin
      cap_in             = cap_ff;
      oldest_in          = oldest_ff;
      cur_in             = cur_ff;
      held_in            = held_ff;
      wr_en              = 1'b0;
      wr_addr            = AW'(slot_cur);
      rd_en              = 1'b0;
      rd_addr            = AW'(slot_cur);
      result.moved       = 1'b0;
      result.src         = SRC_ZERO;
      if (csr_we) begin
         cap_in    = eff_cap(csr_wdata, DEPTH);
         oldest_in = 8'd0;
         cur_in    = 8'd0;
         held_in   = 8'd0;
      end else if (step_en) begin
         case (func)
            FUNC_PUSH: begin
               wr_en        = 1'b1;
               result.moved = 1'b1;
               result.src   = SRC_PUSH;
               if (cur_ff < cap_ff) begin
                  held_in = cur_ff + 8'd1;
                  cur_in  = cur_ff + 8'd1;
               end else begin
                  // slide the window: overwrite the oldest entry
                  wr_addr   = AW'(oldest_ff);
                  oldest_in = (oldest_inc == {1'b0, cap_ff}) ? 8'd0 : oldest_inc[7:0];
                  cur_in    = cap_ff;
                  held_in   = cap_ff;
               end
            end
            FUNC_BACK: begin
               if (cur_ff > 8'd1) begin
                  cur_in       = cur_ff - 8'd1;
                  rd_en        = 1'b1;
                  rd_addr      = AW'(slot_prev);
                  result.moved = 1'b1;
                  result.src   = SRC_MEM;
               end
            end
            FUNC_FWD: begin
               if (cur_ff != 8'd0 && cur_ff < held_ff) begin
                  cur_in       = cur_ff + 8'd1;
                  rd_en        = 1'b1;
                  result.moved = 1'b1;
                  result.src   = SRC_MEM;
               end
            end
            default: begin
               // unused code: leave the history as it is
            end
         endcase
      end
      result.can_back    = (cur_in > 8'd1);
      result.can_forward = (cur_in != 8'd0) && (cur_in < held_in);
      result.held        = held_in;
   end

   // Hold the pointer state
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= eff_cap(CAPACITY_RESET, DEPTH);
         oldest_ff <= 8'd0;
         cur_ff    <= 8'd0;
         held_ff   <= 8'd0;
      end else begin
         cap_ff    <= cap_in;
         oldest_ff <= oldest_in;
         cur_ff    <= cur_in;
         held_ff   <= held_in;
      end
   end

`ifndef SYNTHESIS
   a_cur_le_held: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= held_ff)
      else $error("cursor beyond entry count");

   a_held_le_cap: assert property (@(posedge clock) disable iff (reset)
      held_ff <= cap_ff)
      else $error("entry count beyond capacity");

   a_oldest_lt_cap: assert property (@(posedge clock) disable iff (reset)
      oldest_ff < cap_ff)
      else $error("oldest slot outside window");

   a_back_steps: assert property (@(posedge clock) disable iff (reset)
      step_en && !csr_we && func == FUNC_BACK && cur_ff > 8'd1
      |=> cur_ff == $past(cur_ff) - 8'd1 && held_ff == $past(held_ff))
      else $error("back did not step the cursor by one");
`endif

endmodule

// ===== rtl/back_forward_history_ring.sv =====
// Top level of the back/forward history ring: handshake, result register, output select.
//
//   channel   direction  transfer when            payload
//   req_      in         req_valid & req_ready    func, pos_x, pos_y, pos_z, level
//   rsp_      out        rsp_valid & rsp_ready    moved, out_pos_*, out_level, status
//   csr_      in         csr_we                   capacity (8 bits)
//
// One item per cycle: pointer update and store access are done in the cycle of the
// transfer, and the result is registered, so a result appears the cycle after.
// The result register is the only buffer: req_ready is low while a result waits
// and rsp_ready is low. Synchronous reset empties the history and sets capacity
// to 100 slots; a capacity write also empties the history. No clearing pass.
module back_forward_history_ring
   import bfh_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [4:0]  req_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_moved,
   output logic [31:0] rsp_out_pos_x,
   output logic [31:0] rsp_out_pos_y,
   output logic [31:0] rsp_out_pos_z,
   output logic [4:0]  rsp_out_level,
   output logic        rsp_can_back,
   output logic        rsp_can_forward,
   output logic [7:0]  rsp_entries_held,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic           step;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic           rd_en;
   logic [AW-1:0]  rd_addr;
   bfh_result_type result;
   bfh_entry_type  req_entry;
   bfh_entry_type  rd_entry;
   bfh_entry_type  out_entry;

   logic           rsp_valid_ff, rsp_valid_in;
   bfh_result_type result_ff;
   bfh_entry_type  push_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   assign req_entry.x     = req_pos_x;
   assign req_entry.y     = req_pos_y;
   assign req_entry.z     = req_pos_z;
   assign req_entry.level = req_level;

   bfh_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step),
      .func      (req_func),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .result    (result)
   );

   bfh_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // Result valid: set on an input transfer, drop once the result is taken
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture result status and the pushed entry on each transfer
   always_ff @(posedge clock) begin
      if (step) begin
         result_ff <= result;
         push_ff   <= req_entry;
      end
   end

   // Select the position fields
   always_comb begin
      case (result_ff.src)
         SRC_PUSH: out_entry = push_ff;
         SRC_MEM:  out_entry = rd_entry;
         default:  out_entry = '0;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_moved        = result_ff.moved;
   assign rsp_out_pos_x    = out_entry.x;
   assign rsp_out_pos_y    = out_entry.y;
   assign rsp_out_pos_z    = out_entry.z;
   assign rsp_out_level    = out_entry.level;
   assign rsp_can_back     = result_ff.can_back;
   assign rsp_can_forward  = result_ff.can_forward;
   assign rsp_entries_held = result_ff.held;

endmodule
